// File: rtl/core/tksd_pkg.sv
// Shared constants for the terminal key sequence decoder: byte values of the
// escape sequence characters and the special key codes. No dependencies.
package tksd_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned KeyW  = 11;

  typedef logic [ByteW-1:0] byte_t;
  typedef logic [KeyW-1:0]  key_t;

  localparam byte_t ChLf      = 8'd10;
  localparam byte_t ChEsc     = 8'd27;
  localparam byte_t ChDel     = 8'd127;
  localparam byte_t ChLBrack  = 8'h5B;
  localparam byte_t ChUpperO  = 8'h4F;
  localparam byte_t ChTilde   = 8'h7E;
  localparam byte_t ChSemi    = 8'h3B;
  localparam byte_t ChDigit0  = 8'h30;
  localparam byte_t ChDigit1  = 8'h31;
  localparam byte_t ChDigit2  = 8'h32;
  localparam byte_t ChDigit3  = 8'h33;
  localparam byte_t ChDigit5  = 8'h35;
  localparam byte_t ChDigit6  = 8'h36;
  localparam byte_t ChDigit7  = 8'h37;
  localparam byte_t ChDigit9  = 8'h39;
  localparam byte_t ChUpperA  = 8'h41;
  localparam byte_t ChUpperB  = 8'h42;
  localparam byte_t ChUpperC  = 8'h43;
  localparam byte_t ChUpperD  = 8'h44;
  localparam byte_t ChUpperF  = 8'h46;
  localparam byte_t ChUpperH  = 8'h48;
  localparam byte_t ChUpperP  = 8'h50;
  localparam byte_t ChUpperR  = 8'h52;
  localparam byte_t ChUpperS  = 8'h53;
  localparam byte_t ChUpperT  = 8'h54;
  localparam byte_t ChUpperU  = 8'h55;

  localparam key_t KeyEsc       = 11'd1000;
  localparam key_t KeyUp        = 11'd1001;
  localparam key_t KeyDown      = 11'd1002;
  localparam key_t KeyRight     = 11'd1003;
  localparam key_t KeyLeft      = 11'd1004;
  localparam key_t KeyPgUp      = 11'd1005;
  localparam key_t KeyPgDown    = 11'd1006;
  localparam key_t KeyHome      = 11'd1007;
  localparam key_t KeyEnd       = 11'd1008;
  localparam key_t KeyInsert    = 11'd1009;
  localparam key_t KeyDelete    = 11'd1010;
  localparam key_t KeyF1        = 11'd1011;
  localparam key_t KeyF3        = 11'd1013;
  localparam key_t KeyF4        = 11'd1014;
  localparam key_t KeyF5        = 11'd1015;
  localparam key_t KeyF6        = 11'd1016;
  localparam key_t KeyF9        = 11'd1019;
  localparam key_t KeyF10       = 11'd1020;
  localparam key_t KeyEnter     = 11'd1021;
  localparam key_t KeyBackspace = 11'd1024;
  localparam key_t KeyCtrlLeft  = 11'd1025;
  localparam key_t KeyCtrlRight = 11'd1026;

endpackage

// File: rtl/core/terminal_key_sequence_decoder.sv
// Top level of the terminal key sequence decoder: input register, escape
// sequence state machine and result register. Depends on tksd_pkg.

// The decoder accepts one received byte per clock cycle and delivers at most
// one key code per byte: the byte is held in the input register and its key
// code in the result register. Bytes that extend an escape sequence produce
// no transaction on the output; the byte that completes or breaks the
// sequence produces the key code. The input is stalled only while the input
// register holds a byte and the result register is full and stalled, so a
// steady stream runs at one byte a cycle.
module terminal_key_sequence_decoder (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  tksd_pkg::byte_t rx_byte_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output tksd_pkg::key_t key_code_o
);
  import tksd_pkg::*;

  typedef enum logic [3:0] {
    StIdle,
    StEsc,
    StEsc2,
    StCsi,
    StTilde,
    StCsi1,
    StSemi,
    StSemi5,
    StCsi2,
    StSs3,
    StSkip
  } state_e;

  state_e state_q, state_d;
  key_t   pending_q, pending_d;
  logic   in_valid_q;
  byte_t  rx_byte_q;
  logic   out_valid_q;
  key_t   key_q;
  logic   advance;
  logic   emit;
  key_t   key_d;

  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = in_valid_q && !advance;

  always_comb begin
    state_d   = StIdle;
    pending_d = pending_q;
    emit      = 1'b1;
    key_d     = KeyEsc;
    case (state_q)
      StIdle: begin
        if (rx_byte_q == ChEsc) begin
          emit    = 1'b0;
          state_d = StEsc;
        end else if (rx_byte_q == ChLf) begin
          key_d = KeyEnter;
        end else if (rx_byte_q == ChDel) begin
          key_d = KeyBackspace;
        end else begin
          key_d = KeyW'(rx_byte_q);
        end
      end
      StEsc: begin
        if (rx_byte_q == ChLBrack) begin
          emit    = 1'b0;
          state_d = StCsi;
        end else if (rx_byte_q == ChUpperO) begin
          emit    = 1'b0;
          state_d = StSs3;
        end else if (rx_byte_q == ChDigit2) begin
          emit    = 1'b0;
          state_d = StEsc2;
        end
      end
      StEsc2: begin
        if (rx_byte_q == ChTilde) key_d = KeyInsert;
      end
      StCsi: begin
        case (rx_byte_q)
          ChUpperA: key_d = KeyUp;
          ChUpperB: key_d = KeyDown;
          ChUpperC: key_d = KeyRight;
          ChUpperD: key_d = KeyLeft;
          ChUpperH: key_d = KeyHome;
          ChUpperF: key_d = KeyEnd;
          ChDigit3: begin
            emit      = 1'b0;
            pending_d = KeyDelete;
            state_d   = StTilde;
          end
          ChDigit5: begin
            emit      = 1'b0;
            pending_d = KeyPgUp;
            state_d   = StTilde;
          end
          ChDigit6: begin
            emit      = 1'b0;
            pending_d = KeyPgDown;
            state_d   = StTilde;
          end
          ChDigit1: begin
            emit    = 1'b0;
            state_d = StCsi1;
          end
          ChDigit2: begin
            emit    = 1'b0;
            state_d = StCsi2;
          end
          default: key_d = KeyEsc;
        endcase
      end
      StTilde: begin
        if (rx_byte_q == ChTilde) key_d = pending_q;
      end
      StCsi1: begin
        if (rx_byte_q inside {[ChDigit1:ChDigit5]}) begin
          emit      = 1'b0;
          pending_d = KeyF1 + KeyW'(rx_byte_q - ChDigit1);
          state_d   = StSkip;
        end else if (rx_byte_q inside {[ChDigit7:ChDigit9]}) begin
          emit      = 1'b0;
          pending_d = KeyF6 + KeyW'(rx_byte_q - ChDigit7);
          state_d   = StSkip;
        end else if (rx_byte_q == ChSemi) begin
          emit    = 1'b0;
          state_d = StSemi;
        end
      end
      StSemi: begin
        if (rx_byte_q == ChDigit5) begin
          emit    = 1'b0;
          state_d = StSemi5;
        end
      end
      StSemi5: begin
        if (rx_byte_q == ChUpperD) begin
          key_d = KeyCtrlLeft;
        end else if (rx_byte_q == ChUpperC) begin
          key_d = KeyCtrlRight;
        end
      end
      StCsi2: begin
        if (rx_byte_q == ChDigit0) begin
          emit      = 1'b0;
          pending_d = KeyF9;
          state_d   = StSkip;
        end else if (rx_byte_q == ChDigit1) begin
          emit      = 1'b0;
          pending_d = KeyF10;
          state_d   = StSkip;
        end else if (rx_byte_q == ChTilde) begin
          key_d = KeyInsert;
        end
      end
      StSs3: begin
        case (rx_byte_q)
          ChUpperP: key_d = KeyF1;
          ChUpperR: key_d = KeyF3;
          ChUpperS: key_d = KeyF4;
          ChUpperT: key_d = KeyF5;
          ChUpperU: key_d = KeyF10;
          default:  key_d = KeyEsc;
        endcase
      end
      StSkip: key_d = pending_q;
      default: key_d = KeyEsc;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= StIdle;
      pending_q   <= '0;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= in_valid_q && emit;
        if (in_valid_q) begin
          state_q   <= state_d;
          pending_q <= pending_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      rx_byte_q <= rx_byte_i;
    end
    if (advance && in_valid_q && emit) begin
      key_q <= key_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign key_code_o  = key_q;

  a_key_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (key_code_o <= KeyCtrlRight && key_code_o != 11'd1022 &&
                     key_code_o != 11'd1023))
    else $error("Key code outside the defined set.");

  a_hold_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |=> (in_valid_q && $stable(rx_byte_q) &&
                                  $stable(state_q)))
    else $error("Input register lost a byte while blocked.");

  a_pending_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StTilde || state_q == StSkip) |->
      (pending_q >= KeyPgUp && pending_q <= KeyF10))
    else $error("Pending key not set for a sequence awaiting its last byte.");

endmodule

// File: tb/terminal_key_sequence_decoder_tb.sv
// Self-checking testbench for terminal_key_sequence_decoder: directed key
// sequences, then random bytes and escape sequences, with random idling on
// both sides in all but the last phase. Depends on tksd_pkg and the decoder RTL.
`timescale 1ns / 100ps

module terminal_key_sequence_decoder_tb;
  import tksd_pkg::*;

  localparam int unsigned CycleLimit    = 200000;
  localparam int unsigned DrainCycles   = 8;
  localparam int unsigned BytesPerPhase = 150;
  localparam int unsigned DirectedCount = 26;
  localparam int unsigned MaxPrinted    = 100;

  typedef enum logic [3:0] {
    PsIdle, PsEsc, PsEsc2, PsCsi, PsTilde, PsCsi1, PsSemi, PsSemi5, PsCsi2, PsSs3, PsSkip
  } parse_state_e;

  typedef struct {
    byte_t value;
    bit    has_key;
    key_t  key;
  } key_row_t;

  localparam byte_t CsiFinals [6] = '{ChUpperA, ChUpperB, ChUpperC, ChUpperD, ChUpperH, ChUpperF};
  localparam byte_t TildeDigits [3] = '{ChDigit3, ChDigit5, ChDigit6};
  localparam byte_t Ss3Finals [5] = '{ChUpperP, ChUpperR, ChUpperS, ChUpperT, ChUpperU};
  localparam int unsigned GapPct [3] = '{16, 67, 0};
  localparam int unsigned StallPct [3] = '{67, 16, 0};

  logic  clk_i       = 1'b0;
  logic  rst_ni      = 1'b0;
  logic  in_valid_i  = 1'b0;
  logic  in_stall_o;
  byte_t rx_byte_i   = '0;
  logic  out_valid_o;
  logic  out_stall_i = 1'b0;
  key_t  key_code_o;

  bit    typed_valid = 1'b0;
  key_t  typed_key   = '0;

  int unsigned gap_pct   = GapPct[0];
  int unsigned stall_pct = StallPct[0];
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;

  parse_state_e parse_state = PsIdle;
  key_t         held_key    = '0;
  key_t         expected_keys [$];
  byte_t        key_burst [$];

  key_row_t directed_rows [DirectedCount] = '{
    '{8'h00, 1'b1, 11'd0},
    '{8'hFF, 1'b1, 11'd255},
    '{ChLf, 1'b1, KeyEnter},
    '{ChDel, 1'b1, KeyBackspace},
    '{ChEsc, 1'b0, '0}, '{ChLBrack, 1'b0, '0}, '{ChUpperA, 1'b1, KeyUp},
    '{ChEsc, 1'b0, '0}, '{ChEsc, 1'b1, KeyEsc},
    '{ChEsc, 1'b0, '0}, '{ChLBrack, 1'b0, '0}, '{ChDigit1, 1'b0, '0},
    '{ChDigit5, 1'b0, '0}, '{8'h00, 1'b0, '0},
    '{ChEsc, 1'b0, '0}, '{ChUpperO, 1'b0, '0}, '{ChUpperU, 1'b0, '0},
    '{ChEsc, 1'b0, '0}, '{ChDigit2, 1'b0, '0}, '{ChTilde, 1'b0, '0},
    '{ChEsc, 1'b0, '0}, '{ChLBrack, 1'b0, '0}, '{ChDigit1, 1'b0, '0},
    '{ChSemi, 1'b0, '0}, '{ChDigit5, 1'b0, '0}, '{ChUpperC, 1'b0, '0}
  };

  terminal_key_sequence_decoder i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .rx_byte_i  (rx_byte_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .key_code_o (key_code_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  task automatic report_error(input string msg);
    error_count++;
    if (error_count <= MaxPrinted) $display("mismatch at cycle %0d: %s", cycle_count, msg);
  endtask

  function automatic void decode_byte(input byte_t b, output bit emit, output key_t key);
    parse_state_e nxt;
    key  = KeyEsc;
    emit = 1'b1;
    nxt  = PsIdle;
    case (parse_state)
      PsIdle: begin
        if (b == ChEsc) begin
          emit = 1'b0;
          nxt  = PsEsc;
        end else if (b == ChLf) key = KeyEnter;
        else if (b == ChDel) key = KeyBackspace;
        else key = key_t'(b);
      end
      PsEsc: begin
        if (b == ChLBrack) begin
          emit = 1'b0;
          nxt  = PsCsi;
        end else if (b == ChUpperO) begin
          emit = 1'b0;
          nxt  = PsSs3;
        end else if (b == ChDigit2) begin
          emit = 1'b0;
          nxt  = PsEsc2;
        end
      end
      PsEsc2: begin
        if (b == ChTilde) key = KeyInsert;
      end
      PsCsi: begin
        case (b)
          ChUpperA: key = KeyUp;
          ChUpperB: key = KeyDown;
          ChUpperC: key = KeyRight;
          ChUpperD: key = KeyLeft;
          ChUpperH: key = KeyHome;
          ChUpperF: key = KeyEnd;
          ChDigit3: begin
            emit = 1'b0; held_key = KeyDelete; nxt = PsTilde;
          end
          ChDigit5: begin
            emit = 1'b0; held_key = KeyPgUp; nxt = PsTilde;
          end
          ChDigit6: begin
            emit = 1'b0; held_key = KeyPgDown; nxt = PsTilde;
          end
          ChDigit1: begin
            emit = 1'b0; nxt = PsCsi1;
          end
          ChDigit2: begin
            emit = 1'b0; nxt = PsCsi2;
          end
          default: ;
        endcase
      end
      PsTilde: begin
        if (b == ChTilde) key = held_key;
      end
      PsCsi1: begin
        if (b >= ChDigit1 && b <= ChDigit5) begin
          emit = 1'b0; held_key = KeyF1 + key_t'(b - ChDigit1); nxt = PsSkip;
        end else if (b >= ChDigit7 && b <= ChDigit9) begin
          emit = 1'b0; held_key = KeyF6 + key_t'(b - ChDigit7); nxt = PsSkip;
        end else if (b == ChSemi) begin
          emit = 1'b0; nxt = PsSemi;
        end
      end
      PsSemi: begin
        if (b == ChDigit5) begin
          emit = 1'b0; nxt = PsSemi5;
        end
      end
      PsSemi5: begin
        if (b == ChUpperD) key = KeyCtrlLeft;
        else if (b == ChUpperC) key = KeyCtrlRight;
      end
      PsCsi2: begin
        if (b == ChDigit0) begin
          emit = 1'b0; held_key = KeyF9; nxt = PsSkip;
        end else if (b == ChDigit1) begin
          emit = 1'b0; held_key = KeyF10; nxt = PsSkip;
        end else if (b == ChTilde) key = KeyInsert;
      end
      PsSs3: begin
        if (b == ChUpperP) key = KeyF1;
        else if (b == ChUpperR) key = KeyF3;
        else if (b == ChUpperS) key = KeyF4;
        else if (b == ChUpperT) key = KeyF5;
        else if (b == ChUpperU) key = KeyF10;
      end
      PsSkip: key = held_key;
      default: ;
    endcase
    parse_state = nxt;
  endfunction

  // Mostly well-formed sequences with random content; some are cut short by a random byte.
  function automatic void build_key_burst();
    int unsigned cut;
    key_burst.delete();
    case ($urandom_range(9))
      0, 1: key_burst.push_back(byte_t'($urandom_range(255)));
      2: key_burst = '{ChEsc, ChLBrack, CsiFinals[$urandom_range(5)]};
      3: key_burst = '{ChEsc, ChLBrack, TildeDigits[$urandom_range(2)], ChTilde};
      4: key_burst = '{ChEsc, ChLBrack, ChDigit1,
                       ($urandom_range(1) ? ChDigit1 + byte_t'($urandom_range(4))
                                          : ChDigit7 + byte_t'($urandom_range(2))),
                       byte_t'($urandom_range(255))};
      5: begin
        if ($urandom_range(2) == 0) key_burst = '{ChEsc, ChLBrack, ChDigit2, ChTilde};
        else key_burst = '{ChEsc, ChLBrack, ChDigit2,
                           ($urandom_range(1) ? ChDigit0 : ChDigit1),
                           byte_t'($urandom_range(255))};
      end
      6: key_burst = '{ChEsc, ChLBrack, ChDigit1, ChSemi, ChDigit5,
                       ($urandom_range(1) ? ChUpperC : ChUpperD)};
      7: key_burst = '{ChEsc, ChUpperO, Ss3Finals[$urandom_range(4)]};
      8: key_burst = '{ChEsc, ChDigit2, ChTilde};
      default: key_burst = '{ChEsc, byte_t'($urandom_range(255))};
    endcase
    if (key_burst.size() > 1 && $urandom_range(5) == 0) begin
      cut = $urandom_range(key_burst.size() - 1, 1);
      key_burst[cut] = byte_t'($urandom_range(255));
      while (key_burst.size() > cut + 1) void'(key_burst.pop_back());
    end
  endfunction

  task automatic send_byte(input byte_t value, input bit has_key, input key_t key);
    while ($urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    rx_byte_i   <= value;
    typed_valid <= has_key;
    typed_key   <= key;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  always @(posedge clk_i) begin : key_check
    bit   emit;
    key_t key;
    key_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        decode_byte(rx_byte_i, emit, key);
        if (typed_valid) expected_keys.push_back(typed_key);
        else if (emit) expected_keys.push_back(key);
      end
      if (out_valid_o && !out_stall_i) begin
        if (expected_keys.size() == 0) begin
          report_error($sformatf("key code %0d with none expected", key_code_o));
        end else begin
          want = expected_keys.pop_front();
          if (key_code_o !== want)
            report_error($sformatf("key code %0d, expected %0d", key_code_o, want));
        end
      end
    end
  end

  initial begin
    int unsigned sent;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    foreach (directed_rows[i])
      send_byte(directed_rows[i].value, directed_rows[i].has_key, directed_rows[i].key);
    for (int phase = 0; phase < 3; phase++) begin
      gap_pct   = GapPct[phase];
      stall_pct = StallPct[phase];
      sent      = 0;
      while (sent < BytesPerPhase) begin
        build_key_burst();
        foreach (key_burst[i]) send_byte(key_burst[i], 1'b0, '0);
        sent += key_burst.size();
      end
    end
    in_valid_i  <= 1'b0;
    typed_valid <= 1'b0;
    while (expected_keys.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (expected_keys.size() != 0)
      report_error($sformatf("%0d key codes never delivered", expected_keys.size()));
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
